### src/ckc_pkg.sv
// Shared types, constants and the pixel averaging function of the chroma key compositor.
package ckc_pkg;

  localparam int unsigned CH_W  = 8;
  localparam int unsigned PIX_W = 3 * CH_W;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [PIX_W-1:0] pix_t;

  // action codes
  localparam logic [1:0] ACT_PIXEL   = 2'd0;
  localparam logic [1:0] ACT_BG_RST  = 2'd1;
  localparam logic [1:0] ACT_KEY_RST = 2'd2;

  // register indexes
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_PPF       = 1'b1;

  localparam logic [6:0]  THRESHOLD_RST = 7'd30;
  localparam logic [17:0] PPF_RST       = 18'd76800;
  localparam pix_t        AVG_MASK      = 24'hFEFEFE;
  localparam logic [2:0]  BG_PHASES     = 3'd6;

  function automatic pix_t avg_pix(input pix_t a, input pix_t b);
    avg_pix = (a & b) + (((a ^ b) & AVG_MASK) >> 1);
  endfunction

endpackage

### src/ckc_store.sv
// One frame store: single-port synchronous RAM with registered read.
module ckc_store
  #(parameter int unsigned AW = 17,
    parameter int unsigned DW = 24)
  (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
  );

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

### src/ckc_div.sv
// Restoring divider for one channel: 16-bit dividend, 8-bit quotient.
module ckc_div
  import ckc_pkg::*;
  (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num,
  input  chan_t       den,
  output chan_t       quo,
  output logic        done
  );

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  chan_t       rem_r, rem_nxt;
  chan_t       sh_r, sh_nxt;
  chan_t       q_r, q_nxt;
  logic [8:0]  trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    trial    = {rem_r, sh_r[CH_W-1]};
    if (start) begin
      // quotient fits in 8 bits, so the high byte is already below den
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      rem_nxt  = num[15:8];
      sh_nxt   = num[7:0];
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = 8'(trial - {1'b0, den});
        q_nxt   = {q_r[CH_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[7:0];
        q_nxt   = {q_r[CH_W-2:0], 1'b0};
      end
      sh_nxt  = {sh_r[CH_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule

### src/chroma_key_compositor.sv
// Top level of the chroma key compositor: frame stores, matte and blend.
//
//   channel | ports                                      | dir
//   --------+--------------------------------------------+-----
//   input   | in_valid/in_ready, in_action, in_red/green/blue | in
//   result  | out_valid/out_ready, out_red/green/blue    | out
//   config  | cfg_valid/cfg_ready, cfg_index, cfg_data   | in
//
// One pixel at a time: capture frames pass S_READ and S_OUT, composing to
// foreground or background adds S_CALC, and a blended pixel also waits in
// S_DIV for the 8-step divider and its done strobe.
// The store read issued at accept returns in the next cycle, in S_READ; the
// read-modify-write finishes before the next pixel, so no forwarding.
// Restart actions are taken in S_IDLE and give no result.
// Reset is synchronous; stores are not cleared. A full output register
// holds the next result back until out_ready.
module chroma_key_compositor
  import ckc_pkg::*;
  #(parameter int unsigned MAX_PIXELS = 131072,
    parameter int unsigned KEY_FRAMES = 4)
  (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [17:0] cfg_data
  );

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CW = (AW + 1 > 18) ? AW + 1 : 18;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_CALC = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t         state_r, state_nxt;
  logic [6:0]     thr_r;
  logic [17:0]    ppf_r;
  logic [AW-1:0]  pos_r, pos_nxt;
  logic [2:0]     phase_r, phase_nxt;
  logic [2:0]     key_left_r, key_left_nxt;
  logic           key_first_r, key_first_nxt;
  pix_t           prev_r, prev_nxt;
  pix_t           src_r;
  pix_t           res_r, res_nxt;
  pix_t           bg_r, bg_nxt;
  chan_t          d_r, d_nxt;
  logic           out_valid_r, out_valid_nxt;
  pix_t           out_r;

  logic           accept;
  logic           st_en;
  logic           bg_we, pb_we, key_we;
  pix_t           bg_wd, pb_wd, mn_wd, mx_wd;
  pix_t           bg_rd, pb_rd, mn_rd, mx_rd;
  logic [CW-1:0]  eff, pos_inc;
  logic           frame_end;

  // blend
  logic [8:0]     d2, t3, t2, m, mi;
  logic [15:0]    num [3];
  chan_t          quo [3];
  logic           div_done [3];
  logic           div_start;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign st_en     = accept && (in_action == ACT_PIXEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RST;
      ppf_r <= PPF_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_r <= cfg_data[6:0];
        CFG_PPF:       ppf_r <= cfg_data;
        default:       thr_r <= thr_r;
      endcase
    end
  end

  ckc_store #(.AW(AW), .DW(PIX_W)) u_bg (
    .clk(clk), .en(st_en), .we(bg_we), .addr(pos_r), .wdata(bg_wd), .rdata(bg_rd));
  ckc_store #(.AW(AW), .DW(PIX_W)) u_pb (
    .clk(clk), .en(st_en), .we(pb_we), .addr(pos_r), .wdata(pb_wd), .rdata(pb_rd));
  ckc_store #(.AW(AW), .DW(PIX_W)) u_mn (
    .clk(clk), .en(st_en), .we(key_we), .addr(pos_r), .wdata(mn_wd), .rdata(mn_rd));
  ckc_store #(.AW(AW), .DW(PIX_W)) u_mx (
    .clk(clk), .en(st_en), .we(key_we), .addr(pos_r), .wdata(mx_wd), .rdata(mx_rd));

  always_comb begin
    if (ppf_r == 18'd0) begin
      eff = CW'(1);
    end else if (CW'(ppf_r) > CW'(MAX_PIXELS)) begin
      eff = CW'(MAX_PIXELS);
    end else begin
      eff = CW'(ppf_r);
    end
    pos_inc   = CW'(pos_r) + CW'(1);
    frame_end = (pos_inc >= eff);
  end

  // store updates and matte distance, all in S_READ
  always_comb begin
    chan_t c, p, lo, hi, bl, e;
    logic  key_cap;
    bg_we   = 1'b0;
    pb_we   = 1'b0;
    key_we  = 1'b0;
    bg_wd   = src_r;
    pb_wd   = src_r;
    mn_wd   = src_r;
    mx_wd   = src_r;
    bg_nxt  = bg_rd;
    d_nxt   = d_r;
    key_cap = (phase_r <= 3'd2) && (key_left_r != 3'd0);
    case (phase_r)
      3'd6: begin bg_we = 1'b1; bg_wd = src_r; end
      3'd5: begin bg_we = 1'b1; bg_wd = avg_pix(src_r, bg_rd); end
      3'd4: begin pb_we = 1'b1; pb_wd = src_r; end
      3'd3: begin pb_we = 1'b1; pb_wd = avg_pix(src_r, pb_rd); end
      3'd2: begin
        bg_we  = 1'b1;
        bg_wd  = avg_pix(bg_rd, pb_rd) & AVG_MASK;
        bg_nxt = bg_wd;
      end
      default: bg_we = 1'b0;
    endcase
    if (key_cap) begin
      key_we = 1'b1;
      if (!key_first_r) begin
        for (int k = 0; k < 3; k++) begin
          c  = src_r[k*CH_W +: CH_W];
          lo = mn_rd[k*CH_W +: CH_W];
          hi = mx_rd[k*CH_W +: CH_W];
          mn_wd[k*CH_W +: CH_W] = (c < lo) ? c : lo;
          mx_wd[k*CH_W +: CH_W] = (c > hi) ? c : hi;
        end
      end
    end
    d_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      c  = src_r[k*CH_W +: CH_W];
      p  = prev_r[k*CH_W +: CH_W];
      lo = mn_rd[k*CH_W +: CH_W];
      hi = mx_rd[k*CH_W +: CH_W];
      bl = (p >> 1) + (c >> 1);
      if (bl < lo) begin
        e = lo - bl;
      end else if (bl > hi) begin
        e = bl - hi;
      end else begin
        e = '0;
      end
      if (e > d_nxt) begin
        d_nxt = e;
      end
    end
    if (state_r != S_READ) begin
      bg_we  = 1'b0;
      pb_we  = 1'b0;
      key_we = 1'b0;
      bg_nxt = bg_r;
      d_nxt  = d_r;
    end
  end

  assign d2 = {d_r, 1'b0};
  assign t3 = 9'({2'b00, thr_r} + {1'b0, thr_r, 1'b0});
  assign t2 = {1'b0, thr_r, 1'b0};
  assign m  = d2 - {2'b00, thr_r};
  assign mi = t2 - m;

  always_comb begin
    logic [16:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum    = ({9'd0, src_r[k*CH_W +: CH_W]} * {8'd0, m}) +
               ({9'd0, bg_r[k*CH_W +: CH_W]} * {8'd0, mi});
      num[k] = sum[15:0];
    end
  end

  genvar gk;
  generate
    for (gk = 0; gk < 3; gk++) begin : g_div
      ckc_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(num[gk]),
        .den(t2[7:0]), .quo(quo[gk]), .done(div_done[gk]));
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    key_left_nxt  = key_left_r;
    key_first_nxt = key_first_r;
    prev_nxt      = prev_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_PIXEL:   state_nxt = S_READ;
            ACT_BG_RST:  phase_nxt = BG_PHASES;
            ACT_KEY_RST: begin
              key_left_nxt  = 3'(KEY_FRAMES);
              key_first_nxt = 1'b1;
            end
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        if (phase_r >= 3'd3) begin
          res_nxt   = src_r;
          state_nxt = S_OUT;
        end else if (key_left_r != 3'd0) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CALC;
        end
        prev_nxt = src_r;
        if (frame_end) begin
          pos_nxt  = '0;
          prev_nxt = '0;
          if (phase_r != 3'd0) begin
            phase_nxt = phase_r - 3'd1;
          end
          if ((phase_r <= 3'd2) && (key_left_r != 3'd0)) begin
            key_left_nxt  = key_left_r - 3'd1;
            key_first_nxt = 1'b0;
          end
        end else begin
          pos_nxt = pos_inc[AW-1:0];
        end
      end
      S_CALC: begin
        if (d2 > t3) begin
          res_nxt   = src_r;
          state_nxt = S_OUT;
        end else if ((d2 < {2'b00, thr_r}) || (thr_r == 7'd0)) begin
          res_nxt   = bg_r;
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done[0]) begin
          res_nxt   = {quo[2], quo[1], quo[0]};
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold the result until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      phase_r     <= BG_PHASES;
      key_left_r  <= 3'(KEY_FRAMES);
      key_first_r <= 1'b1;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      key_left_r  <= key_left_nxt;
      key_first_r <= key_first_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (st_en) begin
      src_r <= {in_red, in_green, in_blue};
    end
    if ((state_r == S_OUT) && (!out_valid_r || out_ready)) begin
      out_r <= res_r;
    end
    res_r <= res_nxt;
    bg_r  <= bg_nxt;
    d_r   <= d_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_r[2*CH_W +: CH_W];
  assign out_green = out_r[CH_W +: CH_W];
  assign out_blue  = out_r[0 +: CH_W];

endmodule

### test/tb_chroma_key_compositor.sv
// Self-checking testbench of the chroma key compositor: directed table, an oversized frame, then randomized frames.
module tb_chroma_key_compositor;
  import ckc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXP = 131072;
  localparam int KEYN = 4;
  localparam int LIMIT = 600000;
  localparam logic [1:0] ACT_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_PIXEL;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red, out_green, out_blue;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_THRESHOLD;
  logic [17:0] cfg_data = '0;

  chroma_key_compositor dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // shadow state of the compositor
  pix_t bg_mem[MAXP], part_mem[MAXP], min_mem[MAXP], max_mem[MAXP];
  bit   bg_wr[MAXP], part_wr[MAXP], min_wr[MAXP], max_wr[MAXP];
  pix_t prev_px;
  int   pos, bg_phase, key_left, thr, ppf;
  bit   key_first;

  pix_t pixel_q[$];
  int   errors = 0, cycles = 0, pixels_in = 0, pixels_out = 0, restarts = 0;
  bit   quiet = 1'b0;

  task automatic report(input string msg);
    $display("mismatch @%0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic pix_t mean_pix(input pix_t a, input pix_t b);
    pix_t r;
    logic [8:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum = a[8*k +: 8] + b[8*k +: 8];
      r[8*k +: 8] = sum[8:1];
    end
    return r;
  endfunction

  function automatic int eff_size();
    if (ppf == 0) return 1;
    if (ppf > MAXP) return MAXP;
    return ppf;
  endfunction

  function automatic bit stores_ready(input int n);
    for (int i = 0; i < n; i++)
      if (!(bg_wr[i] && part_wr[i] && min_wr[i] && max_wr[i])) return 1'b0;
    return 1'b1;
  endfunction

  task automatic shadow_reset();
    prev_px = '0; pos = 0; bg_phase = 6; key_left = KEYN; key_first = 1'b1;
    thr = 30; ppf = 76800;
  endtask

  task automatic predict_pixel(input logic [1:0] act, input pix_t px,
                               output bit has, output pix_t res);
    int eff, idx, d, e, bl, c, lo, hi, m, v, s;
    bit kr;
    pix_t bgv, mn, mx;
    has = 1'b0;
    res = '0;
    if (act == ACT_BG_RST) begin
      bg_phase = 6;
      return;
    end
    if (act == ACT_KEY_RST) begin
      key_left = KEYN; key_first = 1'b1;
      return;
    end
    if (act == ACT_NONE) return;
    has = 1'b1;
    eff = eff_size();
    idx = (pos >= MAXP) ? MAXP - 1 : pos;
    kr = (bg_phase <= 2);
    if (bg_phase >= 3) begin
      case (bg_phase)
        6: begin bg_mem[idx] = px; bg_wr[idx] = 1'b1; end
        5: bg_mem[idx] = mean_pix(px, bg_mem[idx]);
        4: begin part_mem[idx] = px; part_wr[idx] = 1'b1; end
        default: part_mem[idx] = mean_pix(px, part_mem[idx]);
      endcase
      res = px;
    end else begin
      if (bg_phase == 2) bg_mem[idx] = mean_pix(bg_mem[idx], part_mem[idx]) & 24'hFEFEFE;
      if (key_left > 0) begin
        if (key_first) begin
          min_mem[idx] = px; max_mem[idx] = px;
          min_wr[idx] = 1'b1; max_wr[idx] = 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) begin
            s = 8 * k;
            if (px[s +: 8] < min_mem[idx][s +: 8]) min_mem[idx][s +: 8] = px[s +: 8];
            if (px[s +: 8] > max_mem[idx][s +: 8]) max_mem[idx][s +: 8] = px[s +: 8];
          end
        end
        res = '0;
      end else begin
        bgv = bg_mem[idx]; mn = min_mem[idx]; mx = max_mem[idx];
        d = 0;
        for (int k = 0; k < 3; k++) begin
          s = 8 * k;
          bl = (prev_px[s +: 8] >> 1) + (px[s +: 8] >> 1);
          lo = mn[s +: 8]; hi = mx[s +: 8];
          e = (bl < lo) ? lo - bl : (bl > hi) ? bl - hi : 0;
          if (e > d) d = e;
        end
        for (int k = 0; k < 3; k++) begin
          s = 8 * k;
          c = px[s +: 8];
          if (2 * d > 3 * thr) v = c;
          else if (2 * d < thr || thr == 0) v = bgv[s +: 8];
          else begin
            m = 2 * d - thr;
            v = (c * m + bgv[s +: 8] * (2 * thr - m)) / (2 * thr);
          end
          res[s +: 8] = v[7:0];
        end
      end
    end
    prev_px = px;
    if (pos + 1 >= eff) begin
      pos = 0; prev_px = '0;
      if (bg_phase > 0) bg_phase--;
      if (kr && key_left > 0) begin
        key_left--; key_first = 1'b0;
      end
    end else begin
      pos++;
    end
  endtask

  // sender stands just after a rising edge; valid stays high between back-to-back beats
  task automatic send_beat(input logic [1:0] act, input pix_t px, input bit typed,
                           input pix_t typed_px);
    int gap;
    bit has;
    pix_t res;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_pixel(act, px, has, res);
    if (has) begin
      pixel_q.push_back(typed ? typed_px : res);
      pixels_in++;
    end else begin
      restarts++;
    end
    in_valid <= 1'b1;
    in_action <= act;
    {in_red, in_green, in_blue} <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [17:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_THRESHOLD) thr = val[6:0];
    else ppf = val;
    @(posedge clk);
  endtask

  // bring the frame position back to zero and start a fresh capture at a new size
  task automatic restart_frames(input int size, input int t);
    cfg_write(CFG_PPF, 18'd1);
    send_beat(ACT_BG_RST, '0, 1'b0, '0);
    send_beat(ACT_PIXEL, pix_t'($urandom), 1'b0, '0);
    drain();
    cfg_write(CFG_PPF, size[17:0]);
    cfg_write(CFG_THRESHOLD, t[17:0]);
    send_beat(ACT_BG_RST, '0, 1'b0, '0);
    send_beat(ACT_KEY_RST, '0, 1'b0, '0);
  endtask

  function automatic pix_t near(input pix_t base, input int span);
    pix_t r;
    int v;
    for (int k = 0; k < 3; k++) begin
      v = base[8*k +: 8] + $urandom_range(0, 2 * span) - span;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      r[8*k +: 8] = v[7:0];
    end
    return r;
  endfunction

  typedef struct packed {
    logic [1:0] act;
    pix_t       px;
    bit         typed;
    pix_t       res;
  } row_t;

  row_t dir_tbl[21] = '{
    '{ACT_NONE,    24'h5A5A5A, 1'b0, 24'h0},
    '{ACT_PIXEL,   24'hFFFFFF, 1'b1, 24'hFFFFFF},
    '{ACT_PIXEL,   24'h000000, 1'b1, 24'h000000},
    '{ACT_PIXEL,   24'hFF0000, 1'b1, 24'hFF0000},
    '{ACT_PIXEL,   24'h00FF00, 1'b1, 24'h00FF00},
    '{ACT_PIXEL,   24'h0000FF, 1'b1, 24'h000000},
    '{ACT_PIXEL,   24'h0000FF, 1'b1, 24'h000000},
    '{ACT_PIXEL,   24'h0000FF, 1'b1, 24'h000000},
    '{ACT_PIXEL,   24'h0000FF, 1'b1, 24'h000000},
    '{ACT_PIXEL,   24'h0000FF, 1'b0, 24'h0},
    '{ACT_PIXEL,   24'hFFFFFF, 1'b0, 24'h0},
    '{ACT_PIXEL,   24'h000000, 1'b0, 24'h0},
    '{ACT_PIXEL,   24'h0010F0, 1'b0, 24'h0},
    '{ACT_KEY_RST, 24'h000000, 1'b0, 24'h0},
    '{ACT_PIXEL,   24'h2020E0, 1'b1, 24'h000000},
    '{ACT_PIXEL,   24'h2020E0, 1'b1, 24'h000000},
    '{ACT_PIXEL,   24'h2020E0, 1'b1, 24'h000000},
    '{ACT_PIXEL,   24'h2020E0, 1'b1, 24'h000000},
    '{ACT_PIXEL,   24'h2828D8, 1'b0, 24'h0},
    '{ACT_BG_RST,  24'h000000, 1'b0, 24'h0},
    '{ACT_PIXEL,   24'h123456, 1'b1, 24'h123456}
  };

  // result side: compare each beat, then draw the next stall
  initial begin
    int stall;
    pix_t want;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) begin
        pixels_out++;
        if (pixel_q.size() == 0) begin
          report($sformatf("unexpected pixel %h%h%h", out_red, out_green, out_blue));
        end else begin
          want = pixel_q.pop_front();
          if (out_red !== want[23:16])
            report($sformatf("red %h, want %h", out_red, want[23:16]));
          if (out_green !== want[15:8])
            report($sformatf("green %h, want %h", out_green, want[15:8]));
          if (out_blue !== want[7:0])
            report($sformatf("blue %h, want %h", out_blue, want[7:0]));
        end
        stall = quiet ? 0 : $urandom_range(0, 17);
        // hold off long enough to back the block up into its input
        if (pixels_out == 150) stall = 400;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int n, size, t, kind, rnd_pixels, phases;
    pix_t base, px;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    shadow_reset();

    // frame size zero acts as one pixel per frame
    cfg_write(CFG_PPF, 18'd0);
    cfg_write(CFG_THRESHOLD, 18'd127);
    foreach (dir_tbl[i]) send_beat(dir_tbl[i].act, dir_tbl[i].px, dir_tbl[i].typed,
                                   dir_tbl[i].res);
    drain();

    // oversized frame, then shrink it mid-frame so the next pixel ends the frame
    restart_frames(262143, 64);
    for (int i = 0; i < 20; i++) send_beat(ACT_PIXEL, pix_t'($urandom), 1'b0, '0);
    drain();
    cfg_write(CFG_PPF, 18'd7);

    rnd_pixels = 0;
    phases = 0;
    while (rnd_pixels < 900) begin
      if (phases > 0) begin
        case (phases % 5)
          1: t = 0;
          2: t = 127;
          default: t = $urandom_range(0, 127);
        endcase
        size = (phases % 7 == 3) ? 1 : $urandom_range(2, 12);
        restart_frames(size, t);
      end
      quiet = ($urandom_range(0, 3) == 0);
      base = pix_t'($urandom);
      n = eff_size() * $urandom_range(11, 15);
      for (int i = 0; i < n; i++) begin
        kind = $urandom_range(0, 39);
        if (kind == 0) begin
          send_beat(ACT_NONE, pix_t'($urandom), 1'b0, '0);
        end else if (kind <= 2 && (pos == 0 || stores_ready(eff_size()))) begin
          send_beat((kind == 1) ? ACT_BG_RST : ACT_KEY_RST, '0, 1'b0, '0);
        end else begin
          if (bg_phase >= 3) px = near(pix_t'($urandom), 128);
          else if (key_left > 0) px = near(base, 6);
          else begin
            case (kind % 4)
              0: px = base;
              1: px = near(base, thr / 2 + 4);
              2: px = near(base, 2 * thr + 8);
              default: px = pix_t'($urandom);
            endcase
          end
          send_beat(ACT_PIXEL, px, 1'b0, '0);
          rnd_pixels++;
        end
      end
      drain();
      phases++;
    end

    drain();
    if (pixel_q.size() != 0) report($sformatf("%0d pixels never came out", pixel_q.size()));
    $display("covered %0d pixels in, %0d out, %0d restart or ignored beats, %0d phases",
             pixels_in, pixels_out, restarts, phases);
    $display("frame sizes 1 to 12 plus clipped oversize, thresholds 0 to 127, %0d cycles",
             cycles);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
